### hw/rtl/rrcc_pkg.sv
// Package for the RGB ratio color classifier: field widths, register indexes,
// channel tags and the class and color name codes.
// No dependencies; imported by every module of the block.
package rrcc_pkg;

   // Field widths.
   localparam int LEVEL_W    = 16;
   localparam int GAIN_W     = 8;
   localparam int LIMIT_W    = 8;
   localparam int SHARE_W    = 8;
   localparam int CLASS_W    = 3;
   localparam int NAME_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Derived datapath widths.
   localparam int SUM_W      = LEVEL_W + 2;          // sum of three levels
   localparam int PROD_W     = LEVEL_W + GAIN_W;     // level times gain
   localparam int DIV_STAGES = SHARE_W;              // one quotient bit per stage
   localparam int TRIAL_W    = SUM_W + SHARE_W;      // room for the shifted divisor
   localparam int RATIO_W    = SHARE_W + LIMIT_W + 1; // (limit + 1) times divisor

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RED_GAIN    = 3'd0,
      REG_GREEN_GAIN  = 3'd1,
      REG_BLUE_GAIN   = 3'd2,
      REG_HIGH_LIMIT  = 3'd3,
      REG_MID_LIMIT   = 3'd4
   } csr_index_type;

   // Register values after reset.
   localparam logic [GAIN_W-1:0]  RED_GAIN_RST   = 8'd100;
   localparam logic [GAIN_W-1:0]  GREEN_GAIN_RST = 8'd150;
   localparam logic [GAIN_W-1:0]  BLUE_GAIN_RST  = 8'd165;
   localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 8'd6;
   localparam logic [LIMIT_W-1:0] MID_LIMIT_RST  = 8'd1;

   // Channel tags of the sorted shares.
   typedef enum logic [1:0] {
      TAG_RED   = 2'd0,
      TAG_GREEN = 2'd1,
      TAG_BLUE  = 2'd2
   } tag_type;

   // Sorter class codes.
   localparam logic [CLASS_W-1:0] CLS_REJECT = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_RED    = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_ORANGE = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_YELLOW = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_GREEN  = 3'd4;
   localparam logic [CLASS_W-1:0] CLS_VIOLET = 3'd5;

   // Color name codes.
   localparam logic [NAME_W-1:0] NAME_RED          = 4'd0;
   localparam logic [NAME_W-1:0] NAME_GREEN        = 4'd1;
   localparam logic [NAME_W-1:0] NAME_BLUE         = 4'd2;
   localparam logic [NAME_W-1:0] NAME_ORANGE       = 4'd3;
   localparam logic [NAME_W-1:0] NAME_MAGENTA      = 4'd4;
   localparam logic [NAME_W-1:0] NAME_YELLOW_GREEN = 4'd5;
   localparam logic [NAME_W-1:0] NAME_BLUE_GREEN   = 4'd6;
   localparam logic [NAME_W-1:0] NAME_INDIGO       = 4'd7;
   localparam logic [NAME_W-1:0] NAME_LIGHT_BLUE   = 4'd8;
   localparam logic [NAME_W-1:0] NAME_TEAL         = 4'd9;
   localparam logic [NAME_W-1:0] NAME_VIOLET       = 4'd10;
   localparam logic [NAME_W-1:0] NAME_YELLOW       = 4'd11;
   localparam logic [NAME_W-1:0] NAME_NO_LIGHT     = 4'd12;

endpackage

### hw/rtl/rgb_ratio_color_classifier.sv
// RGB ratio color classifier: shares, sort, ratio test and color decision.
// Depends on rrcc_pkg and rrcc_divider (three instances, one per channel).
//
// One reading enters per clock cycle while the output side keeps taking
// transfers. An input register forms the channel sum and the three gain
// products, eight stages of restoring division give one share bit each, then a
// sort stage, a stage that multiplies the two ratio limits by the divisor, and
// the decision stage, which is also the output register. Each stage holds
// while its successor is full and stalled, so a stall at the output fills the
// pipeline bubbles before it reaches the input. A reading whose channels sum
// to zero comes out as a reject with the no-light name and the no-light flag
// set. Registers must only be written while idle; the block does not enforce it.
module rgb_ratio_color_classifier
   import rrcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Readings.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] red_level, [31:16] green_level, [47:32] blue_level
   input  logic [47:0]           req_tdata,
   // Results.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] class_code, [6:3] name_index, [14:7] red_share,
   // [22:15] green_share, [30:23] blue_share, [31] zero fill
   output logic [31:0]           rsp_tdata,
   // [0] no_light
   output logic [0:0]            rsp_tuser
);

   localparam int ST_IN    = 0;
   localparam int ST_SORT  = DIV_STAGES + 1;
   localparam int ST_MUL   = ST_SORT + 1;
   localparam int ST_OUT   = ST_MUL + 1;
   localparam int N_STAGES = ST_OUT + 1;

   // Configuration registers.
   logic [GAIN_W-1:0]  red_gain_ff, green_gain_ff, blue_gain_ff;
   logic [LIMIT_W-1:0] high_limit_ff, mid_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_gain_ff   <= RED_GAIN_RST;
         green_gain_ff <= GREEN_GAIN_RST;
         blue_gain_ff  <= BLUE_GAIN_RST;
         high_limit_ff <= HIGH_LIMIT_RST;
         mid_limit_ff  <= MID_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_RED_GAIN:   red_gain_ff   <= csr_wdata;
            REG_GREEN_GAIN: green_gain_ff <= csr_wdata;
            REG_BLUE_GAIN:  blue_gain_ff  <= csr_wdata;
            REG_HIGH_LIMIT: high_limit_ff <= csr_wdata;
            REG_MID_LIMIT:  mid_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage handshake: a stage loads when it is empty or its successor loads.
   logic [N_STAGES-1:0] valid_ff, valid_in;
   logic [N_STAGES:0]   stage_ready;

   always_comb begin
      stage_ready[N_STAGES] = rsp_tready;
      for (int k = N_STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign valid_in   = {valid_ff[N_STAGES-2:0], req_tvalid};
   assign req_tready = stage_ready[ST_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Input stage: channel sum and gain products.
   logic [LEVEL_W-1:0] red_level, green_level, blue_level;
   logic [SUM_W-1:0]   sum_ff;
   logic [PROD_W-1:0]  red_prod_ff, green_prod_ff, blue_prod_ff;
   logic               nl_ff [DIV_STAGES+1];

   assign red_level   = req_tdata[15:0];
   assign green_level = req_tdata[31:16];
   assign blue_level  = req_tdata[47:32];

   always_ff @(posedge clock) begin
      if (stage_ready[ST_IN]) begin
         sum_ff        <= SUM_W'(red_level) + SUM_W'(green_level) + SUM_W'(blue_level);
         red_prod_ff   <= PROD_W'(red_level) * PROD_W'(red_gain_ff);
         green_prod_ff <= PROD_W'(green_level) * PROD_W'(green_gain_ff);
         blue_prod_ff  <= PROD_W'(blue_level) * PROD_W'(blue_gain_ff);
         nl_ff[0]      <= (red_level == '0) && (green_level == '0) && (blue_level == '0);
      end
   end

   // The no-light flag rides alongside the divider stages.
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_nl
      always_ff @(posedge clock) begin
         if (stage_ready[j]) begin
            nl_ff[j] <= nl_ff[j-1];
         end
      end
   end

   // Share division, one pipeline per channel.
   logic [DIV_STAGES-1:0] div_en;
   logic [SHARE_W-1:0]    red_q, green_q, blue_q;

   assign div_en = stage_ready[DIV_STAGES:1];

   rrcc_divider u_div_red (
      .clock    (clock),
      .stage_en (div_en),
      .dividend (red_prod_ff),
      .divisor  (sum_ff),
      .quotient (red_q)
   );

   rrcc_divider u_div_green (
      .clock    (clock),
      .stage_en (div_en),
      .dividend (green_prod_ff),
      .divisor  (sum_ff),
      .quotient (green_q)
   );

   rrcc_divider u_div_blue (
      .clock    (clock),
      .stage_en (div_en),
      .dividend (blue_prod_ff),
      .divisor  (sum_ff),
      .quotient (blue_q)
   );

   // Sort stage: order the shares, tag the extremes, form spread and divisor.
   logic [SHARE_W-1:0] lo_v, mid_v, hi_v, swap_v;
   logic [SHARE_W-1:0] spread_in, den_in;
   tag_type            tmin_in, tmax_in;

   logic [SHARE_W-1:0] rs_s_ff, gs_s_ff, bs_s_ff, spread_s_ff, den_s_ff;
   tag_type            tmin_s_ff, tmax_s_ff;
   logic               nl_s_ff;

   always_comb begin
      swap_v = '0;
      lo_v   = red_q;
      mid_v  = green_q;
      hi_v   = blue_q;
      if (lo_v > mid_v) begin
         swap_v = lo_v;
         lo_v   = mid_v;
         mid_v  = swap_v;
      end
      if (mid_v > hi_v) begin
         swap_v = mid_v;
         mid_v  = hi_v;
         hi_v   = swap_v;
      end
      if (lo_v > mid_v) begin
         swap_v = lo_v;
         lo_v   = mid_v;
         mid_v  = swap_v;
      end

      // On a tie the first of red, green, blue takes the position.
      if (lo_v == red_q) begin
         tmin_in = TAG_RED;
      end else if (lo_v == green_q) begin
         tmin_in = TAG_GREEN;
      end else begin
         tmin_in = TAG_BLUE;
      end
      if (hi_v == red_q) begin
         tmax_in = TAG_RED;
      end else if (hi_v == green_q) begin
         tmax_in = TAG_GREEN;
      end else begin
         tmax_in = TAG_BLUE;
      end

      spread_in = hi_v - lo_v;
      den_in    = (mid_v == lo_v) ? SHARE_W'(1) : mid_v - lo_v;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[ST_SORT]) begin
         rs_s_ff     <= red_q;
         gs_s_ff     <= green_q;
         bs_s_ff     <= blue_q;
         spread_s_ff <= spread_in;
         den_s_ff    <= den_in;
         tmin_s_ff   <= tmin_in;
         tmax_s_ff   <= tmax_in;
         nl_s_ff     <= nl_ff[DIV_STAGES];
      end
   end

   // Limit stage: floor(spread / den) > limit exactly when spread >= (limit + 1) * den.
   logic [RATIO_W-1:0] high_bound_ff, mid_bound_ff;
   logic [SHARE_W-1:0] rs_m_ff, gs_m_ff, bs_m_ff, spread_m_ff;
   tag_type            tmin_m_ff, tmax_m_ff;
   logic               nl_m_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[ST_MUL]) begin
         high_bound_ff <= (RATIO_W'(high_limit_ff) + RATIO_W'(1)) * RATIO_W'(den_s_ff);
         mid_bound_ff  <= (RATIO_W'(mid_limit_ff) + RATIO_W'(1)) * RATIO_W'(den_s_ff);
         rs_m_ff       <= rs_s_ff;
         gs_m_ff       <= gs_s_ff;
         bs_m_ff       <= bs_s_ff;
         spread_m_ff   <= spread_s_ff;
         tmin_m_ff     <= tmin_s_ff;
         tmax_m_ff     <= tmax_s_ff;
         nl_m_ff       <= nl_s_ff;
      end
   end

   // Decision stage: pick class and color name from the ratio and the tags.
   logic               above_high, above_mid;
   logic [CLASS_W-1:0] class_in;
   logic [NAME_W-1:0]  name_in;

   assign above_high = RATIO_W'(spread_m_ff) >= high_bound_ff;
   assign above_mid  = RATIO_W'(spread_m_ff) >= mid_bound_ff;

   always_comb begin
      class_in = CLS_REJECT;
      name_in  = NAME_NO_LIGHT;
      if (above_high) begin
         case (tmax_m_ff)
            TAG_RED: begin
               class_in = CLS_RED;
               name_in  = NAME_RED;
            end
            TAG_GREEN: begin
               class_in = CLS_GREEN;
               name_in  = NAME_GREEN;
            end
            default: begin
               class_in = CLS_REJECT;
               name_in  = NAME_BLUE;
            end
         endcase
      end else if (above_mid) begin
         case (tmax_m_ff)
            TAG_RED: begin
               class_in = (tmin_m_ff == TAG_BLUE) ? CLS_ORANGE : CLS_REJECT;
               name_in  = (tmin_m_ff == TAG_BLUE) ? NAME_ORANGE : NAME_MAGENTA;
            end
            TAG_GREEN: begin
               class_in = CLS_REJECT;
               name_in  = (tmin_m_ff == TAG_BLUE) ? NAME_YELLOW_GREEN : NAME_BLUE_GREEN;
            end
            default: begin
               class_in = CLS_REJECT;
               name_in  = (tmin_m_ff == TAG_GREEN) ? NAME_INDIGO : NAME_LIGHT_BLUE;
            end
         endcase
      end else begin
         case (tmin_m_ff)
            TAG_RED: begin
               class_in = CLS_VIOLET;
               name_in  = NAME_TEAL;
            end
            TAG_GREEN: begin
               class_in = CLS_VIOLET;
               name_in  = NAME_VIOLET;
            end
            default: begin
               class_in = CLS_YELLOW;
               name_in  = NAME_YELLOW;
            end
         endcase
      end

      // A zero channel sum overrides everything.
      if (nl_m_ff) begin
         class_in = CLS_REJECT;
         name_in  = NAME_NO_LIGHT;
      end
   end

   // Output register.
   logic [CLASS_W-1:0] class_ff;
   logic [NAME_W-1:0]  name_ff;
   logic [SHARE_W-1:0] rs_o_ff, gs_o_ff, bs_o_ff;
   logic               nl_o_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[ST_OUT]) begin
         class_ff <= class_in;
         name_ff  <= name_in;
         rs_o_ff  <= nl_m_ff ? '0 : rs_m_ff;
         gs_o_ff  <= nl_m_ff ? '0 : gs_m_ff;
         bs_o_ff  <= nl_m_ff ? '0 : bs_m_ff;
         nl_o_ff  <= nl_m_ff;
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = {1'b0, bs_o_ff, gs_o_ff, rs_o_ff, name_ff, class_ff};
   assign rsp_tuser  = nl_o_ff;

endmodule

### hw/rtl/rrcc_divider.sv
// Pipelined restoring divider for one channel share: one quotient bit per stage.
// Depends on rrcc_pkg; each stage loads when its enable from the top level is high.
module rrcc_divider
   import rrcc_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [PROD_W-1:0]     dividend,
   input  logic [SUM_W-1:0]      divisor,
   output logic [SHARE_W-1:0]    quotient
);

   logic [PROD_W-1:0]  rem_ff [DIV_STAGES];
   logic [SUM_W-1:0]   dvs_ff [DIV_STAGES];
   logic [SHARE_W-1:0] quo_ff [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
      localparam int K = DIV_STAGES - 1 - j;

      logic [PROD_W-1:0]  rem_prev;
      logic [SUM_W-1:0]   dvs_prev;
      logic [SHARE_W-1:0] quo_prev;
      logic [TRIAL_W-1:0] shifted;
      logic [PROD_W-1:0]  rem_in;
      logic [SHARE_W-1:0] quo_in;

      // The first step takes the operands, later steps the previous stage.
      if (j == 0) begin : g_first
         assign rem_prev = dividend;
         assign dvs_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign dvs_prev = dvs_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      // Subtract the divisor aligned to this quotient bit when it fits.
      always_comb begin
         shifted = TRIAL_W'(dvs_prev) << K;
         rem_in  = rem_prev;
         quo_in  = quo_prev;
         if (TRIAL_W'(rem_prev) >= shifted) begin
            rem_in    = PROD_W'(TRIAL_W'(rem_prev) - shifted);
            quo_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in;
            dvs_ff[j] <= dvs_prev;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule
